// ===== rtl/ist_pkg.sv =====
// Package: constants, types and op codes for the interval set table.
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;
  localparam int Capacity = 16;
  localparam int AddrBits = 32;
  localparam int IdxBits = $clog2(Capacity);
  localparam int CntBits = $clog2(Capacity + 1);
  localparam int EntBits = 2 * AddrBits;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;
  // piece counts during remove can reach twice the capacity
  typedef logic [CntBits:0] wcnt_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_REMOVE = 3'd1, OP_CONTAINS = 3'd2,
    OP_NORMALIZE = 3'd3, OP_DUMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_INVERTED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RM_CNT, S_RM_CHK, S_RM_WR, S_CT_SCAN, S_DP_SCAN,
    S_NM_SCAN, S_NM_MIN, S_NM_APPLY, S_NM_COPY, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] status;
    logic hit;
    addr_t entry_start;
    addr_t entry_end;
    logic entry_present;
    logic [4:0] entry_count;
    logic last;
  } res_t;

  typedef struct packed {
    logic [2:0] op;
    addr_t range_lo;
    addr_t range_hi;
  } req_t;
endpackage
`default_nettype wire

// ===== rtl/ist_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface ist_req_if;
  import ist_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] op;
  addr_t range_lo;
  addr_t range_hi;
  modport source(output valid, op, range_lo, range_hi, input ready);
  modport sink(input valid, op, range_lo, range_hi, output ready);
endinterface

interface ist_res_if;
  import ist_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic hit;
  addr_t entry_start;
  addr_t entry_end;
  logic entry_present;
  logic [4:0] entry_count;
  logic last;
  modport source(output valid, status, hit, entry_start, entry_end, entry_present,
                 entry_count, last, input ready);
  modport sink(input valid, status, hit, entry_start, entry_end, entry_present,
               entry_count, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ist_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ist_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/interval_set_table.sv =====
// Top level: interval set table with a sequencer over two entry banks.
//
//  channel | dir | payload
//  req     | in  | op, range_lo, range_hi
//  res     | out | status, hit, entry_start, entry_end, entry_present,
//          |     | entry_count, last
//
// Add, inverted ranges and unknown ops go straight to the result; contains scans all entries.
// Dump returns one result per entry, or one empty result for an empty table. Remove is a
// count pass and a rewrite pass, and the rewrite pauses once per split entry. Normalize
// does one min-search pass per non-empty entry plus one more, then a copy step.
// Reset clears the state, count, bank select, output valid, scan indices and scan flags only.
// A stalled result holds the sequencer; a new item is taken only when idle.
`timescale 1ns / 1ps
`default_nettype none
module interval_set_table
  import ist_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  ist_req_if.sink   req,
  ist_res_if.source res
);
  state_e state, state_next;
  req_t   cur;
  logic   bank;          // bank holding the live table
  cnt_t   used;
  cnt_t   i;             // read index (address issued)
  cnt_t   j;             // processed index
  logic   rvalid;        // read data of index j valid this cycle
  cnt_t   wp;            // write pointer in the other bank
  wcnt_t  np, nk;        // split pieces and kept entries
  logic   hit;
  logic   full_err;
  logic   second_piece;
  addr_t  hold_e;        // end of the entry being split
  // normalize scratch
  addr_t  thr_s;         // entries up to this (start,pos) are consumed
  logic   have_thr;
  cnt_t   thr_pos;
  addr_t  bs, be;
  cnt_t   bpos;
  logic   bfound;
  addr_t  ms, me;        // merged run being built
  logic   mopen;
  res_t   obuf;
  logic   ovalid;
  logic   ovalid_set;
  logic   more_dump;

  // RAM ports
  logic       we [2];
  idx_t       waddr [2];
  logic [EntBits-1:0] wdata [2], rdata [2];
  idx_t       raddr [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    ist_ram #(.Width(EntBits), .Depth(Capacity)) u_ram (
      .clk(clk), .we(we[b]), .waddr(waddr[b]), .wdata(wdata[b]),
      .raddr(raddr[b]), .rdata(rdata[b]));
  end

  addr_t rs, re;
  assign rs = bank ? rdata[1][EntBits-1:AddrBits] : rdata[0][EntBits-1:AddrBits];
  assign re = bank ? rdata[1][AddrBits-1:0] : rdata[0][AddrBits-1:0];

  logic rm_disj, rm_cov, rm_head, rm_tail, split_hold;
  always_comb begin
    rm_disj = (cur.range_hi <= rs) || (cur.range_lo >= re);
    rm_cov  = (cur.range_lo <= rs) && (cur.range_hi >= re);
    rm_head = cur.range_lo <= rs;
    rm_tail = cur.range_hi >= re;
    // a split writes two pieces, so the scan pauses while the second is written
    split_hold = (state == S_RM_WR) && rvalid && !rm_disj && !rm_cov && !rm_head &&
                 !rm_tail;
  end

  // normalize: candidate greater than threshold in (start,pos) order
  logic nm_after, nm_better;
  always_comb begin
    nm_after = !have_thr || (rs > thr_s) || ((rs == thr_s) && (j > thr_pos));
    nm_better = !bfound || (rs < bs);
  end

  logic scan_done;
  assign scan_done = (i >= used);

  // status and count of an item taken in idle
  status_e acc_status;
  cnt_t    acc_count;
  logic    acc_add;
  always_comb begin
    acc_status = ST_OK;
    acc_count = used;
    acc_add = 1'b0;
    if (req.op == OP_ADD) begin
      if (req.range_lo > req.range_hi) acc_status = ST_INVERTED;
      else if (used >= cnt_t'(Capacity)) acc_status = ST_FULL;
      else begin
        acc_add = 1'b1;
        acc_count = used + cnt_t'(1);
      end
    end else if (req.op == OP_REMOVE && req.range_lo > req.range_hi) begin
      acc_status = ST_INVERTED;
    end
  end

  logic dp_go;
  assign dp_go = (state == S_DP_SCAN) && more_dump && (!ovalid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) begin
        priority if (req.op == OP_REMOVE && req.range_lo <= req.range_hi) begin
          state_next = S_RM_CNT;
        end else if (req.op == OP_CONTAINS) state_next = S_CT_SCAN;
        else if (req.op == OP_DUMP) state_next = S_DP_SCAN;
        else if (req.op == OP_NORMALIZE) state_next = S_NM_SCAN;
        else state_next = S_OUT;
      end
      S_RM_CNT:  if (scan_done && !rvalid) state_next = S_RM_CHK;
      S_RM_CHK:  state_next = full_err ? S_OUT : S_RM_WR;
      S_RM_WR:   if (scan_done && !rvalid) state_next = S_OUT;
      S_CT_SCAN: if (scan_done && !rvalid) state_next = S_OUT;
      S_DP_SCAN: if (!more_dump && ovalid && res.ready) state_next = S_IDLE;
      S_NM_SCAN: if (scan_done && !rvalid) state_next = S_NM_MIN;
      S_NM_MIN:  state_next = S_NM_APPLY;
      S_NM_APPLY: state_next = bfound ? S_NM_SCAN : S_NM_COPY;
      S_NM_COPY: state_next = S_OUT;
      S_OUT:     if (ovalid && res.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b] = 1'b0; waddr[b] = '0; wdata[b] = '0; raddr[b] = i[IdxBits-1:0];
    end
    req.ready = (state == S_IDLE);
    res.valid = ovalid;
    res.status = obuf.status;
    res.hit = obuf.hit;
    res.entry_start = obuf.entry_start;
    res.entry_end = obuf.entry_end;
    res.entry_present = obuf.entry_present;
    res.entry_count = obuf.entry_count;
    res.last = obuf.last;
    if (state == S_IDLE && req.valid && acc_add) begin
      we[bank] = 1'b1;
      waddr[bank] = used[IdxBits-1:0];
      wdata[bank] = {req.range_lo, req.range_hi};
    end
    if (state == S_RM_WR && second_piece) begin
      // [hi,e) goes in front of [s,lo)
      we[!bank] = 1'b1;
      waddr[!bank] = idx_t'(np - wcnt_t'(1)); wdata[!bank] = {cur.range_hi, hold_e};
    end else if (state == S_RM_WR && rvalid && !rm_cov) begin
      we[!bank] = 1'b1;
      if (rm_disj) begin
        waddr[!bank] = wp[IdxBits-1:0]; wdata[!bank] = {rs, re};
      end else if (rm_head) begin
        waddr[!bank] = wp[IdxBits-1:0]; wdata[!bank] = {cur.range_hi, re};
      end else if (rm_tail) begin
        waddr[!bank] = wp[IdxBits-1:0]; wdata[!bank] = {rs, cur.range_lo};
      end else begin
        // split pieces fill the head downward
        waddr[!bank] = idx_t'(np - wcnt_t'(1)); wdata[!bank] = {rs, cur.range_lo};
      end
    end
    if (state == S_NM_APPLY && mopen && (!bfound || bs > me)) begin
      we[!bank] = 1'b1; waddr[!bank] = wp[IdxBits-1:0]; wdata[!bank] = {ms, me};
    end
  end

  always_comb begin
    ovalid_set = 1'b0;
    if (state == S_IDLE && req.valid && state_next == S_OUT) ovalid_set = 1'b1;
    if (state == S_RM_CHK && full_err) ovalid_set = 1'b1;
    if ((state == S_RM_WR || state == S_CT_SCAN) && scan_done && !rvalid) ovalid_set = 1'b1;
    if (state == S_NM_COPY) ovalid_set = 1'b1;
    if (dp_go && (used == '0 || rvalid)) ovalid_set = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; bank <= 1'b0; used <= '0; ovalid <= 1'b0;
      i <= '0; j <= '0; rvalid <= 1'b0; second_piece <= 1'b0; more_dump <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_set || (ovalid && !res.ready);
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= '{op: req.op, range_lo: req.range_lo, range_hi: req.range_hi};
          i <= '0; j <= '0; rvalid <= 1'b0; np <= '0; nk <= '0; wp <= '0;
          hit <= 1'b0; have_thr <= 1'b0; bfound <= 1'b0; mopen <= 1'b0;
          obuf <= '{status: acc_status, hit: 1'b0, entry_start: '0, entry_end: '0,
                    entry_present: 1'b0, entry_count: acc_count, last: 1'b1};
          if (acc_add) used <= used + cnt_t'(1);
          more_dump <= (req.op == OP_DUMP);
        end
        S_RM_CNT, S_CT_SCAN, S_NM_SCAN, S_RM_WR: begin
          rvalid <= !scan_done && !split_hold;
          if (!scan_done && !split_hold) i <= i + cnt_t'(1);
          if (rvalid) j <= j + cnt_t'(1);
          if (state == S_RM_CNT && rvalid && !rm_cov) begin
            if (rm_disj || rm_head || rm_tail) nk <= nk + wcnt_t'(1);
            else np <= np + wcnt_t'(2);
          end
          if (state == S_RM_CNT && scan_done && !rvalid) begin
            full_err <= (np + nk) > wcnt_t'(Capacity);
          end
          if (state == S_CT_SCAN && rvalid && cur.range_lo >= rs && cur.range_lo < re)
            hit <= 1'b1;
          if (state == S_CT_SCAN && scan_done && !rvalid) obuf.hit <= hit;
          if (state == S_NM_SCAN && rvalid && rs < re && nm_after && nm_better) begin
            bfound <= 1'b1; bs <= rs; be <= re; bpos <= j;
          end
          if (state == S_RM_WR) begin
            if (split_hold) begin
              np <= np - wcnt_t'(1); hold_e <= re; second_piece <= 1'b1;
            end else if (second_piece) begin
              np <= np - wcnt_t'(1); second_piece <= 1'b0;
            end else if (rvalid && !rm_cov) begin
              wp <= wp + cnt_t'(1);
            end
            if (scan_done && !rvalid) begin
              bank <= !bank; used <= wp; obuf.entry_count <= wp;
            end
          end
        end
        S_RM_CHK: begin
          i <= '0; j <= '0; rvalid <= 1'b0;
          if (full_err) obuf.status <= ST_FULL;
          else wp <= cnt_t'(np);
        end
        S_DP_SCAN: if (dp_go) begin
          if (used == '0) begin
            more_dump <= 1'b0;
          end else if (rvalid) begin
            obuf.entry_start <= rs; obuf.entry_end <= re; obuf.entry_present <= 1'b1;
            obuf.last <= (j + cnt_t'(1) == used);
            rvalid <= 1'b0;
            j <= j + cnt_t'(1);
            if (j + cnt_t'(1) == used) more_dump <= 1'b0;
          end else begin
            rvalid <= 1'b1; i <= i + cnt_t'(1);
          end
        end
        S_NM_MIN: ;
        S_NM_APPLY: begin
          i <= '0; j <= '0; rvalid <= 1'b0; bfound <= 1'b0;
          if (bfound) begin
            have_thr <= 1'b1; thr_s <= bs; thr_pos <= bpos;
            if (mopen && bs <= me) begin
              if (be > me) me <= be;
            end else begin
              if (mopen) wp <= wp + cnt_t'(1);
              ms <= bs; me <= be; mopen <= 1'b1;
            end
          end else if (mopen) begin
            wp <= wp + cnt_t'(1);
          end
        end
        S_NM_COPY: begin
          bank <= !bank; used <= wp; obuf.entry_count <= wp;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= cnt_t'(Capacity)) else $error("entry count over capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ovalid) else $error("request taken with result pending");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
